/* hw/rtl/rgmtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgmtc_pkg: shared types and constants of the redundant GMT/MET time counter
// Holds the command codes, the 400-day cycle length, the item and result
// records passed between the accumulator front end and the breakdown pipe.
// ----------------------------------------------------------------------------
package rgmtc_pkg;

  localparam int unsigned NUM_ACCU_DEFAULT = 3;
  localparam int unsigned TIME_W           = 36;

  // 400 days in milliseconds
  localparam logic [TIME_W-1:0] CYCLE_MS = 36'd34560000000;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_START_MET = 2'd1,
    FUNC_RESET_MET = 2'd2,
    FUNC_LOAD_GMT  = 2'd3
  } func_e;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              met_active;
  } item_t;

  typedef struct packed {
    logic [8:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [9:0] millis;
    logic       met_active;
  } result_t;

  // Subtract one 400-day cycle when the value is beyond it.
  function automatic logic [TIME_W-1:0] wrap_once(logic [TIME_W:0] v);
    logic [TIME_W:0] r;
    r = v;
    if (v > {1'b0, CYCLE_MS}) begin
      r = v - {1'b0, CYCLE_MS};
    end
    return r[TIME_W-1:0];
  endfunction

endpackage

/* hw/rtl/rgmtc_breakdown.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgmtc_breakdown: millisecond count to days/hours/minutes/seconds/millis
// Five-register pipeline with per-stage valid bits. Each constant division
// is a reciprocal multiply that is exact over the operand range, followed
// one stage later by the remainder.
// ----------------------------------------------------------------------------
module rgmtc_breakdown (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rgmtc_pkg::item_t    in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rgmtc_pkg::result_t  out_result_o
);

  localparam int unsigned NUM_STG = 5;

  // day = 2^10 * 84375 ms, hour = 2^7 * 28125, minute = 2^5 * 1875, second = 2^3 * 125
  localparam logic [63:0] DAY_DIV   = 64'd84375;
  localparam logic [63:0] HOUR_DIV  = 64'd28125;
  localparam logic [63:0] MIN_DIV   = 64'd1875;
  localparam logic [63:0] SEC_DIV   = 64'd125;
  localparam int unsigned DAY_SHIFT  = 43;
  localparam int unsigned HOUR_SHIFT = 35;
  localparam int unsigned MIN_SHIFT  = 33;
  localparam int unsigned SEC_SHIFT  = 31;
  localparam logic [63:0] DAY_MAGIC64  = ((64'd1 << DAY_SHIFT) + DAY_DIV - 64'd1) / DAY_DIV;
  localparam logic [63:0] HOUR_MAGIC64 = ((64'd1 << HOUR_SHIFT) + HOUR_DIV - 64'd1) / HOUR_DIV;
  localparam logic [63:0] MIN_MAGIC64  = ((64'd1 << MIN_SHIFT) + MIN_DIV - 64'd1) / MIN_DIV;
  localparam logic [63:0] SEC_MAGIC64  = ((64'd1 << SEC_SHIFT) + SEC_DIV - 64'd1) / SEC_DIV;
  localparam logic [26:0] DAY_MAGIC  = DAY_MAGIC64[26:0];
  localparam logic [20:0] HOUR_MAGIC = HOUR_MAGIC64[20:0];
  localparam logic [22:0] MIN_MAGIC  = MIN_MAGIC64[22:0];
  localparam logic [24:0] SEC_MAGIC  = SEC_MAGIC64[24:0];
  localparam logic [9:0]  DAYS_WRAP  = 10'd400;

  logic [NUM_STG-1:0] stg_valid_q;
  logic [NUM_STG-1:0] stg_ready;

  // stage 0: captured time
  logic [35:0] s0_time_q;
  logic        s0_run_q;
  // stage 1: day quotient
  logic [35:0] s1_time_q;
  logic [9:0]  s1_qday_q;
  logic        s1_run_q;
  // stage 2: days and ms within the day
  logic [8:0]  s2_days_q;
  logic [26:0] s2_msd_q;
  logic        s2_run_q;
  // stage 3: hour, minute-of-day and second-of-day quotients
  logic [8:0]  s3_days_q;
  logic [4:0]  s3_hours_q;
  logic [10:0] s3_mind_q;
  logic [16:0] s3_secd_q;
  logic [26:0] s3_msd_q;
  logic        s3_run_q;
  // stage 4: result register
  rgmtc_pkg::result_t res_q;

  logic [52:0] day_prod;
  logic [26:0] day_rem;
  logic [26:0] msd;
  logic [8:0]  days;
  logic [40:0] hour_prod;
  logic [44:0] min_prod;
  logic [48:0] sec_prod;
  logic [10:0] min_rem;
  logic [16:0] sec_rem;
  logic [26:0] ms_rem;

  // a stage advances when it is empty or its successor advances
  always_comb begin
    stg_ready[NUM_STG-1] = !stg_valid_q[NUM_STG-1] || out_ready_i;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      stg_ready[k] = !stg_valid_q[k] || stg_ready[k+1];
    end
  end

  assign in_ready_o   = stg_ready[0];
  assign out_valid_o  = stg_valid_q[NUM_STG-1];
  assign out_result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= '0;
    end else begin
      if (stg_ready[0]) begin
        stg_valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (stg_ready[k]) begin
          stg_valid_q[k] <= stg_valid_q[k-1];
        end
      end
    end
  end

  // stage datapath
  assign day_prod = 53'(s0_time_q[35:10]) * 53'(DAY_MAGIC);

  assign day_rem = 27'(s1_time_q[35:10]) - 27'(s1_qday_q) * 27'(DAY_DIV);
  assign msd     = {day_rem[16:0], s1_time_q[9:0]};
  assign days    = (s1_qday_q >= DAYS_WRAP) ? 9'(s1_qday_q - DAYS_WRAP) : s1_qday_q[8:0];

  assign hour_prod = 41'(s2_msd_q[26:7]) * 41'(HOUR_MAGIC);
  assign min_prod  = 45'(s2_msd_q[26:5]) * 45'(MIN_MAGIC);
  assign sec_prod  = 49'(s2_msd_q[26:3]) * 49'(SEC_MAGIC);

  assign min_rem = s3_mind_q - 11'(s3_hours_q) * 11'd60;
  assign sec_rem = s3_secd_q - 17'(s3_mind_q) * 17'd60;
  assign ms_rem  = s3_msd_q - 27'(s3_secd_q) * 27'd1000;

  always_ff @(posedge clk_i) begin
    if (stg_ready[0]) begin
      s0_time_q <= in_item_i.time_ms;
      s0_run_q  <= in_item_i.met_active;
    end
    if (stg_ready[1]) begin
      s1_time_q <= s0_time_q;
      s1_qday_q <= day_prod[52:43];
      s1_run_q  <= s0_run_q;
    end
    if (stg_ready[2]) begin
      s2_days_q <= days;
      s2_msd_q  <= msd;
      s2_run_q  <= s1_run_q;
    end
    if (stg_ready[3]) begin
      s3_days_q  <= s2_days_q;
      s3_hours_q <= hour_prod[39:35];
      s3_mind_q  <= min_prod[43:33];
      s3_secd_q  <= sec_prod[47:31];
      s3_msd_q   <= s2_msd_q;
      s3_run_q   <= s2_run_q;
    end
    if (stg_ready[4]) begin
      res_q.days       <= s3_days_q;
      res_q.hours      <= s3_hours_q;
      res_q.minutes    <= min_rem[5:0];
      res_q.seconds    <= sec_rem[5:0];
      res_q.millis     <= ms_rem[9:0];
      res_q.met_active <= s3_run_q;
    end
  end

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_q.millis < 10'd1000) && (res_q.seconds < 6'd60) &&
                    (res_q.minutes < 6'd60) && (res_q.hours < 5'd24) &&
                    (res_q.days < 9'd400))
    else $error("breakdown result field out of range");

endmodule

/* hw/rtl/redundant_gmt_met_time_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundant_gmt_met_time_counter: redundant GMT and MET millisecond counters
// Keeps redundant GMT and MET accumulators, applies tick, start, reset and
// load commands, and reports the selected copy as days, hours, minutes,
// seconds and milliseconds.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake                  Payload
// -------  ---------  -------------------------  ---------------------------------------
// in       input      in_valid_i / in_ready_o    func_i, elapsed_ms_i, accu_index_i,
//                                                clock_select_i
// out      output     out_valid_o / out_ready_i  days_o, hours_o, minutes_o, seconds_o,
//                                                millis_o, met_active_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i (initial GMT, ms)
//
// One item per cycle while the output is not stalled; the result is registered in
// turn at capture, day quotient, day remainder, h/m/s quotients and remainders.
// The accumulators update at the accepting edge, so the next item sees them.
// Reset clears the accumulators, the MET flags, the initial GMT register and
// the pipeline valid bits. A stage holds while its successor holds, and empty
// stages fill, so the input stalls only once all five stages hold items.
// The cfg channel is always ready.
// ----------------------------------------------------------------------------
module redundant_gmt_met_time_counter #(
  parameter int unsigned NUM_ACCUMULATORS = rgmtc_pkg::NUM_ACCU_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [1:0]  accu_index_i,
  input  logic        clock_select_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  days_o,
  output logic [4:0]  hours_o,
  output logic [5:0]  minutes_o,
  output logic [5:0]  seconds_o,
  output logic [9:0]  millis_o,
  output logic        met_active_o,
  // register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [35:0] cfg_data_i
);

  localparam int unsigned IDX_W = (NUM_ACCUMULATORS > 1) ? $clog2(NUM_ACCUMULATORS) : 1;
  localparam int unsigned TW    = rgmtc_pkg::TIME_W;

  logic [TW-1:0] gmt_q [NUM_ACCUMULATORS];
  logic [TW-1:0] gmt_d [NUM_ACCUMULATORS];
  logic [TW-1:0] met_q [NUM_ACCUMULATORS];
  logic [TW-1:0] met_d [NUM_ACCUMULATORS];
  logic          met_active_q, met_active_d;
  logic          start_req_q, start_req_d;
  logic [TW-1:0] cfg_q;

  logic               in_fire;
  rgmtc_pkg::func_e   func;
  logic [IDX_W-1:0]   sel_idx;
  rgmtc_pkg::item_t   item;
  rgmtc_pkg::result_t result;

  assign in_fire     = in_valid_i && in_ready_o;
  assign func        = rgmtc_pkg::func_e'(func_i);
  assign cfg_ready_o = 1'b1;

  // Initial GMT register: take every write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Next state of the accumulators and the MET flags for the offered item.
  always_comb begin
    gmt_d        = gmt_q;
    met_d        = met_q;
    met_active_d = met_active_q;
    start_req_d  = start_req_q;
    unique case (func)
      rgmtc_pkg::FUNC_TICK: begin
        // advance every GMT copy; advance MET only with the old run flag
        for (int i = 0; i < NUM_ACCUMULATORS; i++) begin
          gmt_d[i] = rgmtc_pkg::wrap_once({1'b0, gmt_q[i]} + (TW + 1)'(elapsed_ms_i));
          if (met_active_q) begin
            met_d[i] = rgmtc_pkg::wrap_once({1'b0, met_q[i]} + (TW + 1)'(elapsed_ms_i));
          end
        end
        // the start request takes effect one tick late
        met_active_d = start_req_q;
      end
      rgmtc_pkg::FUNC_START_MET: begin
        start_req_d = 1'b1;
      end
      rgmtc_pkg::FUNC_RESET_MET: begin
        for (int i = 0; i < NUM_ACCUMULATORS; i++) begin
          met_d[i] = '0;
        end
      end
      rgmtc_pkg::FUNC_LOAD_GMT: begin
        for (int i = 0; i < NUM_ACCUMULATORS; i++) begin
          gmt_d[i] = rgmtc_pkg::wrap_once({1'b0, cfg_q});
        end
      end
      default: begin
      end
    endcase
  end

  // Commit the state only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ACCUMULATORS; i++) begin
        gmt_q[i] <= '0;
        met_q[i] <= '0;
      end
      met_active_q <= 1'b0;
      start_req_q  <= 1'b0;
    end else if (in_fire) begin
      gmt_q        <= gmt_d;
      met_q        <= met_d;
      met_active_q <= met_active_d;
      start_req_q  <= start_req_d;
    end
  end

  // Saturate an out-of-range index to the last copy.
  always_comb begin
    if ({1'b0, accu_index_i} >= 3'(NUM_ACCUMULATORS)) begin
      sel_idx = IDX_W'(NUM_ACCUMULATORS - 1);
    end else begin
      sel_idx = accu_index_i[IDX_W-1:0];
    end
  end

  // Report the state after this item has been applied.
  assign item.time_ms    = clock_select_i ? met_d[sel_idx] : gmt_d[sel_idx];
  assign item.met_active = met_active_d;

  rgmtc_breakdown u_breakdown (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (result)
  );

  assign days_o       = result.days;
  assign hours_o      = result.hours;
  assign minutes_o    = result.minutes;
  assign seconds_o    = result.seconds;
  assign millis_o     = result.millis;
  assign met_active_o = result.met_active;

  a_run_flag_on_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && func == rgmtc_pkg::FUNC_TICK) |=> $stable(met_active_q))
    else $error("MET run flag changed outside a tick");

  a_gmt_hold_on_met_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (func == rgmtc_pkg::FUNC_START_MET || func == rgmtc_pkg::FUNC_RESET_MET)
    |=> gmt_q[0] == $past(gmt_q[0]))
    else $error("GMT changed on a MET command");

  a_copies_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gmt_q[NUM_ACCUMULATORS-1] == gmt_q[0]) && (met_q[NUM_ACCUMULATORS-1] == met_q[0]))
    else $error("redundant accumulators disagree");

  a_gmt_within_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> gmt_q[0] <= rgmtc_pkg::CYCLE_MS)
    else $error("GMT beyond one 400-day cycle");

endmodule

/* tb/time_counter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_counter_checker: result predictor and scoreboard for the GMT/MET counter
// Watches the item, result and register channels, keeps its own copy of the
// redundant accumulators and run flags, and compares each result it sees
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module time_counter_checker #(
  parameter int unsigned NUM_ACCU = rgmtc_pkg::NUM_ACCU_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [1:0]  accu_index_i,
  input  logic        clock_select_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [8:0]  days_i,
  input  logic [4:0]  hours_i,
  input  logic [5:0]  minutes_i,
  input  logic [5:0]  seconds_i,
  input  logic [9:0]  millis_i,
  input  logic        met_active_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [35:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          gmt_wraps_o,
  output int          met_wraps_o
);
  import rgmtc_pkg::*;

  localparam longint unsigned CYCLE_LEN = CYCLE_MS;

  logic [35:0] gmt_copy [NUM_ACCU];
  logic [35:0] met_copy [NUM_ACCU];
  logic        met_run;
  logic        met_req;
  logic [35:0] gmt_preset;
  result_t     due_q [$];
  int          failures;
  int          checked;
  int          gmt_wraps;
  int          met_wraps;

  // Drop one 400-day cycle when the sum lies beyond it.
  function automatic logic [35:0] fold_400d(longint unsigned v);
    return (v > CYCLE_LEN) ? 36'(v - CYCLE_LEN) : 36'(v);
  endfunction

  function automatic result_t split_time(logic [35:0] t, logic run);
    result_t         r;
    longint unsigned ms;
    longint unsigned secs;
    ms           = t;
    secs         = ms / 1000;
    r.days       = 9'((secs / 86400) % 400);
    r.hours      = 5'((secs / 3600) % 24);
    r.minutes    = 6'((secs / 60) % 60);
    r.seconds    = 6'(secs % 60);
    r.millis     = 10'(ms % 1000);
    r.met_active = run;
    return r;
  endfunction

  function automatic int field_bad(string name, logic [35:0] want, logic [35:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    result_t         want;
    longint unsigned sum;
    int              slot;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ACCU; i++) begin
        gmt_copy[i] = '0;
        met_copy[i] = '0;
      end
      met_run    = 1'b0;
      met_req    = 1'b0;
      gmt_preset = '0;
      due_q.delete();
      failures   = 0;
      checked    = 0;
      gmt_wraps  = 0;
      met_wraps  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        gmt_preset = cfg_data_i;
      end

      if (in_valid_i && in_ready_i) begin
        case (func_i)
          FUNC_TICK: begin
            for (int i = 0; i < NUM_ACCU; i++) begin
              sum = gmt_copy[i];
              sum += elapsed_ms_i;
              if (i == 0 && sum > CYCLE_LEN) gmt_wraps++;
              gmt_copy[i] = fold_400d(sum);
              if (met_run) begin
                sum = met_copy[i];
                sum += elapsed_ms_i;
                if (i == 0 && sum > CYCLE_LEN) met_wraps++;
                met_copy[i] = fold_400d(sum);
              end
            end
            met_run = met_req;
          end
          FUNC_START_MET: met_req = 1'b1;
          FUNC_RESET_MET: begin
            for (int i = 0; i < NUM_ACCU; i++) met_copy[i] = '0;
          end
          default: begin
            for (int i = 0; i < NUM_ACCU; i++) gmt_copy[i] = fold_400d(gmt_preset);
          end
        endcase
        slot = (accu_index_i >= NUM_ACCU) ? NUM_ACCU - 1 : accu_index_i;
        due_q.push_back(split_time(clock_select_i ? met_copy[slot] : gmt_copy[slot],
                                   met_run));
      end

      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          $error("result with no item outstanding: days %0d millis %0d", days_i, millis_i);
          failures++;
        end else begin
          want = due_q.pop_front();
          failures += field_bad("days", want.days, days_i);
          failures += field_bad("hours", want.hours, hours_i);
          failures += field_bad("minutes", want.minutes, minutes_i);
          failures += field_bad("seconds", want.seconds, seconds_i);
          failures += field_bad("millis", want.millis, millis_i);
          failures += field_bad("met_active", want.met_active, met_active_i);
          checked++;
        end
      end
    end
    fail_count_o <= failures;
    pending_o    <= due_q.size();
    checked_o    <= checked;
    gmt_wraps_o  <= gmt_wraps;
    met_wraps_o  <= met_wraps;
  end

endmodule

/* tb/tb_redundant_gmt_met_time_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_redundant_gmt_met_time_counter: stimulus and verdict for the time counter
// Drives directed and random tick, start, reset and load items, GMT settings
// at and around the 400-day edge, under varying sender gaps and receiver
// stalls. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_redundant_gmt_met_time_counter;
  import rgmtc_pkg::*;

  localparam int unsigned NUM_ACCU = NUM_ACCU_DEFAULT;
  localparam int          CYCLE_LIMIT    = 100_000;
  localparam int          RESET_CYCLES   = 11;
  localparam int          TAIL_CYCLES    = 16;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          PRESSURE_ITEMS = 80;
  localparam int          SEGMENT_ITEMS  = 170;
  localparam logic [35:0] MAX_MS         = '1;
  localparam logic [35:0] CYCLE          = CYCLE_MS;
  localparam logic        SEL_GMT        = 1'b0;
  localparam logic        SEL_MET        = 1'b1;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  func_e       item_func    = FUNC_TICK;
  logic [15:0] item_ms      = '0;
  logic [1:0]  item_slot    = '0;
  logic        item_clock   = SEL_GMT;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [8:0]  days;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [9:0]  millis;
  logic        met_active;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [35:0] cfg_data     = '0;

  int fail_count;
  int pending;
  int checked;
  int gmt_wraps;
  int met_wraps;

  // Stall knobs: sender gap odds are used only by the stimulus process, the
  // receiver odds and the long hold request are handed over with NBAs.
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_arm     = 1'b0;
  logic hold_used    = 1'b0;
  int   hold_left    = 0;
  int   cycle_count  = 0;

  int n_items = 0;
  int n_presets = 0;
  int n_by_func [4] = '{0, 0, 0, 0};

  redundant_gmt_met_time_counter #(
    .NUM_ACCUMULATORS(NUM_ACCU)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (item_func),
    .elapsed_ms_i  (item_ms),
    .accu_index_i  (item_slot),
    .clock_select_i(item_clock),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .days_o        (days),
    .hours_o       (hours),
    .minutes_o     (minutes),
    .seconds_o     (seconds),
    .millis_o      (millis),
    .met_active_o  (met_active),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  time_counter_checker #(
    .NUM_ACCU(NUM_ACCU)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (item_func),
    .elapsed_ms_i  (item_ms),
    .accu_index_i  (item_slot),
    .clock_select_i(item_clock),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .days_i        (days),
    .hours_i       (hours),
    .minutes_i     (minutes),
    .seconds_i     (seconds),
    .millis_i      (millis),
    .met_active_i  (met_active),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .gmt_wraps_o   (gmt_wraps),
    .met_wraps_o   (met_wraps)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold that starts when armed and
  // is counted down here, so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_used) begin
      out_ready <= 1'b0;
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: end the run if it goes far beyond the slowest legal run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still due", cycle_count, pending);
    $display("FAIL");
    $finish;
  end

  // Offer one item and hold it until accepted. Valid is left high afterwards
  // so that back-to-back items never lower and raise it in one step; a gap
  // lowers it first and the next item raises it on a later edge.
  task automatic send_item(func_e f, logic [15:0] ms, logic [1:0] slot, logic clock_sel);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid   <= 1'b1;
    item_func  <= f;
    item_ms    <= ms;
    item_slot  <= slot;
    item_clock <= clock_sel;
    do @(posedge clk); while (!in_ready);
    n_items++;
    n_by_func[f]++;
  endtask

  // Random item: mostly ticks, so the accumulators travel far, with the
  // commands mixed in; elapsed time leans on the extremes.
  task automatic send_random_item();
    int          pick;
    func_e       f;
    logic [15:0] ms;
    pick = $urandom_range(99);
    if (pick < 70) f = FUNC_TICK;
    else if (pick < 80) f = FUNC_START_MET;
    else if (pick < 90) f = FUNC_RESET_MET;
    else f = FUNC_LOAD_GMT;
    pick = $urandom_range(99);
    if (pick < 50) ms = 16'($urandom);
    else if (pick < 70) ms = '1;
    else if (pick < 80) ms = '0;
    else ms = 16'($urandom_range(1000));
    send_item(f, ms, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_preset(logic [35:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_presets++;
  endtask

  // Initial GMT choices: both ends, the 400-day edge, beyond it, and the
  // last stretch before the wrap so random ticks cross it.
  function automatic logic [35:0] pick_preset();
    case ($urandom_range(6))
      0:       return '0;
      1:       return CYCLE;
      2:       return CYCLE - 36'($urandom_range(200000));
      3:       return CYCLE + 36'($urandom);
      4:       return MAX_MS;
      5:       return {4'($urandom_range(15)), 32'($urandom)};
      default: return 36'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: run flag lags the start request by one tick, MET only
    // counts once running, index 3 saturates to the last copy.
    send_item(FUNC_TICK,      16'd0,     2'd0, SEL_GMT);
    send_item(FUNC_TICK,      16'hFFFF,  2'd1, SEL_MET);
    send_item(FUNC_START_MET, 16'd0,     2'd2, SEL_GMT);
    send_item(FUNC_TICK,      16'd1000,  2'd3, SEL_MET);
    send_item(FUNC_TICK,      16'hFFFF,  2'd0, SEL_MET);
    send_item(FUNC_RESET_MET, 16'hFFFF,  2'd1, SEL_MET);
    send_item(FUNC_TICK,      16'd12345, 2'd2, SEL_MET);

    // Exactly 400 days loads unchanged and reads as day 0; one more ms wraps.
    settle();
    write_preset(CYCLE);
    send_item(FUNC_LOAD_GMT,  16'd0,     2'd0, SEL_GMT);
    send_item(FUNC_TICK,      16'd0,     2'd1, SEL_GMT);
    send_item(FUNC_TICK,      16'd1,     2'd2, SEL_GMT);

    // Last ms of the cycle: every breakdown field at its top value.
    settle();
    write_preset(CYCLE - 36'd1);
    send_item(FUNC_LOAD_GMT,  16'd0,     2'd3, SEL_GMT);
    send_item(FUNC_TICK,      16'd1,     2'd0, SEL_GMT);
    send_item(FUNC_TICK,      16'hFFFF,  2'd1, SEL_GMT);

    // Register beyond 400 days: the load folds it once.
    settle();
    write_preset(MAX_MS);
    send_item(FUNC_LOAD_GMT,  16'd0,     2'd2, SEL_GMT);
    send_item(FUNC_TICK,      16'hFFFF,  2'd0, SEL_MET);

    settle();
    write_preset(CYCLE + 36'd1);
    send_item(FUNC_LOAD_GMT,  16'd0,     2'd1, SEL_GMT);

    settle();
    write_preset('0);
    send_item(FUNC_LOAD_GMT,  16'd0,     2'd0, SEL_GMT);
    send_item(FUNC_RESET_MET, 16'd0,     2'd2, SEL_MET);
    send_item(FUNC_START_MET, 16'd0,     2'd1, SEL_MET);
    send_item(FUNC_TICK,      16'hFFFF,  2'd3, SEL_GMT);
    send_item(FUNC_RESET_MET, 16'd0,     2'd0, SEL_MET);

    // Random segments under each stall pattern, each with a fresh preset.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 47; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 47; end
        default: begin tx_idle_pct = 29; rx_stall_pct <= 29; end
      endcase
      for (int k = 0; k < 2; k++) begin
        settle();
        write_preset(pick_preset());
        send_item(FUNC_LOAD_GMT, 16'($urandom), 2'($urandom_range(3)), SEL_GMT);
        repeat (SEGMENT_ITEMS) send_random_item();
      end
    end

    // Back-pressure: receiver holds off while the sender keeps offering.
    settle();
    write_preset(pick_preset());
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    hold_arm <= 1'b1;
    repeat (PRESSURE_ITEMS) send_random_item();

    // Drain, then keep watching for stray results.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d items (%0d ticks, %0d MET starts, %0d MET resets, %0d GMT loads)",
             n_items, n_by_func[FUNC_TICK], n_by_func[FUNC_START_MET],
             n_by_func[FUNC_RESET_MET], n_by_func[FUNC_LOAD_GMT]);
    $display("%0d results compared, %0d preset writes, 400-day wraps: GMT %0d, MET %0d",
             checked, n_presets, gmt_wraps, met_wraps);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
